// File: design/mfewc_pkg.sv
package mfewc_pkg;

    localparam int RING_DEPTH = 32;
    localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FILL_W     = $clog2(RING_DEPTH + 1);

    localparam int TIME_W     = 32;
    localparam int MAC_W      = 48;
    localparam int RSSI_W     = 8;
    localparam int CHAN_W     = 4;
    localparam int LEN_W      = 12;
    localparam int FC_W       = 8;
    localparam int RECENT_W   = 6;
    localparam int S_TDATA_W  = 168;
    localparam int M_TDATA_W  = 184;

    localparam logic [FILL_W-1:0]   RING_FULL     = FILL_W'(RING_DEPTH);
    localparam logic [IDX_W-1:0]    RING_LAST_IDX = IDX_W'(RING_DEPTH - 1);
    localparam logic [RECENT_W-1:0] RECENT_MAX    = 6'd63;

    localparam logic [FC_W-1:0]  SUBTYPE_MASK  = 8'hF0;
    localparam logic [FC_W-1:0]  KIND_DEAUTH   = 8'hC0;
    localparam logic [FC_W-1:0]  KIND_DISASSOC = 8'hA0;
    localparam logic [LEN_W-1:0] MIN_FRAME_LEN = 12'd24;

    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic                     is_deauth;
        logic signed [RSSI_W-1:0] rssi;
        logic [CHAN_W-1:0]        channel;
    } event_meta_t;

    typedef struct packed {
        logic [TIME_W-1:0] time_ms;
        logic [MAC_W-1:0]  dst;
        logic [MAC_W-1:0]  src;
        event_meta_t       meta;
    } event_t;

    typedef struct packed {
        logic clear;
        logic sample;
    } scan_ctl_t;

endpackage

// File: design/mfewc_event_mem.sv
module mfewc_event_mem (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [mfewc_pkg::IDX_W-1:0] wr_addr,
    input  mfewc_pkg::event_t        wr_data,
    input  logic                     rd_en,
    input  logic [mfewc_pkg::IDX_W-1:0] rd_addr,
    output mfewc_pkg::event_t        rd_data
);
    import mfewc_pkg::*;

    logic [TIME_W-1:0] time_mem [RING_DEPTH];
    logic [MAC_W-1:0]  dst_mem  [RING_DEPTH];
    logic [MAC_W-1:0]  src_mem  [RING_DEPTH];
    event_meta_t       meta_mem [RING_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            time_mem[wr_addr] <= wr_data.time_ms;
            dst_mem[wr_addr]  <= wr_data.dst;
            src_mem[wr_addr]  <= wr_data.src;
            meta_mem[wr_addr] <= wr_data.meta;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data.time_ms <= time_mem[rd_addr];
            rd_data.dst     <= dst_mem[rd_addr];
            rd_data.src     <= src_mem[rd_addr];
            rd_data.meta    <= meta_mem[rd_addr];
        end
    end

endmodule

// File: design/mfewc_window_scan.sv
module mfewc_window_scan (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  mfewc_pkg::scan_ctl_t           ctl,
    input  logic [mfewc_pkg::TIME_W-1:0]   now_ms,
    input  logic [mfewc_pkg::TIME_W-1:0]   window_ms,
    input  logic [mfewc_pkg::TIME_W-1:0]   time_ms,
    output logic [mfewc_pkg::RECENT_W-1:0] recent
);
    import mfewc_pkg::*;

    logic [RECENT_W-1:0] count_reg;
    logic [RECENT_W-1:0] count_next;
    logic [TIME_W-1:0]   age;
    logic                is_recent;

    // The age is taken modulo 2^32, so a timestamp just before a wrap still counts.
    assign age       = now_ms - time_ms;
    assign is_recent = (age <= window_ms);

    always_comb begin
        count_next = count_reg;
        if (ctl.clear) begin
            count_next = '0;
        end else if (ctl.sample && is_recent && (count_reg != RECENT_MAX)) begin
            count_next = count_reg + RECENT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign recent = count_reg;

endmodule

// File: design/mgmt_frame_event_window_counter.sv
// Management-frame event window counter.
// Input items arrive on the s_ channel. tuser carries the command (frame or
// query); tdata carries the time and the frame header fields. A deauth or
// disassoc management frame of at least 24 bytes is written into a ring of
// RING_DEPTH events at the edge where the item is accepted, overwriting the
// oldest entry once the ring is full.
// Every item gives one result item on the m_ channel: whether it was recorded,
// the total event count, how many stored events lie within window_ms of the
// item's time, and the newest event.
// The sequencer steps from idle through scan and wait to done after acceptance; an
// item that finds the ring empty goes from idle straight to done. The single read
// port of the event memory sets the scan: each stored timestamp is read once, then
// the newest entry. One item is in work at a time and s_tready is high only while
// the sequencer is idle, so a new item is taken only after the last one's result
// has been loaded into the output register.
// A result waits in the output register while the receiver stalls; the next
// item may still be accepted and worked on, and its result is held back until
// the output register is free.
// Reset clears the event count, the ring pointer, the fill count and the
// output valid, and sets window_ms to 10000. The memory itself is not cleared.
module mgmt_frame_event_window_counter (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [mfewc_pkg::TIME_W-1:0]      cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [31:0] now_ms, [32] is_management, [44:33] frame_length,
    // [52:45] frame_control, [60:53] frame_rssi, [64:61] frame_channel,
    // [112:65] frame_dst, [160:113] frame_src, [167:161] zero
    input  logic [mfewc_pkg::S_TDATA_W-1:0]   s_tdata,
    // [0] command
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] recorded, [32:1] total_events, [38:33] recent_events,
    // [39] last_valid, [40] last_is_deauth, [48:41] last_rssi,
    // [52:49] last_channel, [100:53] last_dst, [148:101] last_src,
    // [180:149] last_time, [183:181] zero
    output logic [mfewc_pkg::M_TDATA_W-1:0]   m_tdata
);
    import mfewc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_WAIT = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [TIME_W-1:0] window_reg;
    logic [TIME_W-1:0] write_count_reg, write_count_next;
    logic [IDX_W-1:0]  write_pos_reg, write_pos_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] issue_cnt_reg, issue_cnt_next;
    logic              rd_vld_reg;
    logic              rd_last_reg;
    logic              recorded_reg;
    logic [TIME_W-1:0] now_reg;
    event_t            last_evt_reg;
    logic              last_valid_reg;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // Input fields.
    logic              in_command;
    logic [TIME_W-1:0] in_now;
    logic              in_mgmt;
    logic [LEN_W-1:0]  in_len;
    logic [FC_W-1:0]   in_fc;
    logic [RSSI_W-1:0] in_rssi;
    logic [CHAN_W-1:0] in_chan;
    logic [MAC_W-1:0]  in_dst;
    logic [MAC_W-1:0]  in_src;
    logic [FC_W-1:0]   in_sub;

    logic              accept;
    logic              record;
    event_t            wr_evt;
    logic              rd_en;
    logic              rd_is_last;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  last_idx;
    event_t            rd_data;
    scan_ctl_t         scan_ctl;
    logic [RECENT_W-1:0] recent;
    logic              out_load;

    assign in_command = s_tuser;
    assign in_now     = s_tdata[31:0];
    assign in_mgmt    = s_tdata[32];
    assign in_len     = s_tdata[44:33];
    assign in_fc      = s_tdata[52:45];
    assign in_rssi    = s_tdata[60:53];
    assign in_chan    = s_tdata[64:61];
    assign in_dst     = s_tdata[112:65];
    assign in_src     = s_tdata[160:113];
    assign in_sub     = in_fc & SUBTYPE_MASK;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign record   = accept && (in_command == CMD_FRAME) && in_mgmt &&
                      (in_len >= MIN_FRAME_LEN) &&
                      ((in_sub == KIND_DEAUTH) || (in_sub == KIND_DISASSOC));

    assign wr_evt.time_ms        = in_now;
    assign wr_evt.dst            = in_dst;
    assign wr_evt.src            = in_src;
    assign wr_evt.meta.is_deauth = (in_sub == KIND_DEAUTH);
    assign wr_evt.meta.rssi      = in_rssi;
    assign wr_evt.meta.channel   = in_chan;

    // Ring bookkeeping is updated at the edge where the item is accepted.
    always_comb begin
        write_count_next = write_count_reg;
        write_pos_next   = write_pos_reg;
        fill_next        = fill_reg;
        if (record) begin
            write_count_next = write_count_reg + TIME_W'(1);
            write_pos_next   = (write_pos_reg == RING_LAST_IDX) ? '0
                                                                : write_pos_reg + IDX_W'(1);
            if (fill_reg != RING_FULL) begin
                fill_next = fill_reg + FILL_W'(1);
            end
        end
    end

    assign last_idx = (write_pos_reg == '0) ? RING_LAST_IDX : write_pos_reg - IDX_W'(1);

    // The scan reads slots 0 .. fill-1 for the window count, then the newest slot.
    assign rd_en      = (state_reg == S_SCAN);
    assign rd_is_last = (issue_cnt_reg == fill_reg);
    assign rd_addr    = rd_is_last ? last_idx : issue_cnt_reg[IDX_W-1:0];

    assign scan_ctl.clear  = accept;
    assign scan_ctl.sample = rd_vld_reg && !rd_last_reg;

    assign out_load = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next     = state_reg;
        issue_cnt_next = issue_cnt_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    issue_cnt_next = '0;
                    state_next     = (fill_next == '0) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                issue_cnt_next = issue_cnt_reg + FILL_W'(1);
                if (rd_is_last) begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT: begin
                if (rd_vld_reg && rd_last_reg) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            window_reg      <= 32'd10000;
            write_count_reg <= '0;
            write_pos_reg   <= '0;
            fill_reg        <= '0;
            issue_cnt_reg   <= '0;
            rd_vld_reg      <= 1'b0;
            rd_last_reg     <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            write_count_reg <= write_count_next;
            write_pos_reg   <= write_pos_next;
            fill_reg        <= fill_next;
            issue_cnt_reg   <= issue_cnt_next;
            rd_vld_reg      <= rd_en;
            rd_last_reg     <= rd_en && rd_is_last;
            m_tvalid_reg    <= m_tvalid_next;
            if (cfg_wr_en) begin
                window_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            recorded_reg   <= record;
            now_reg        <= in_now;
            last_valid_reg <= (fill_next != '0);
            last_evt_reg   <= '0;
        end else if (rd_vld_reg && rd_last_reg) begin
            last_evt_reg   <= rd_data;
        end
        if (out_load) begin
            m_tdata_reg <= {3'b000,
                            last_evt_reg.time_ms,
                            last_evt_reg.src,
                            last_evt_reg.dst,
                            last_evt_reg.meta.channel,
                            last_evt_reg.meta.rssi,
                            last_evt_reg.meta.is_deauth,
                            last_valid_reg,
                            recent,
                            write_count_reg,
                            recorded_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    mfewc_event_mem u_event_mem (
        .aclk    (aclk),
        .wr_en   (record),
        .wr_addr (write_pos_reg),
        .wr_data (wr_evt),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mfewc_window_scan u_window_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (scan_ctl),
        .now_ms    (now_reg),
        .window_ms (window_reg),
        .time_ms   (rd_data.time_ms),
        .recent    (recent)
    );

    // The fill count never runs past the ring size.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= RING_FULL)
        else $error("fill count exceeds ring depth");

    // The newest-entry read only returns while waiting for it.
    a_last_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_vld_reg && rd_last_reg) |-> (state_reg == S_WAIT))
        else $error("newest-entry read returned outside the wait state");

    // A recorded frame advances the event count by exactly one.
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        record |=> (write_count_reg == $past(write_count_reg) + TIME_W'(1)))
        else $error("event count did not advance on a recorded frame");

    // A pending result is never replaced before the receiver takes it.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_tvalid_reg || m_tready))
        else $error("output register loaded while a result was stalled");

endmodule

// File: sim/event_window_checker.sv
`timescale 1ns / 1ps

module event_window_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [mfewc_pkg::TIME_W-1:0]    cfg_wr_data,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [mfewc_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                            s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [mfewc_pkg::M_TDATA_W-1:0] m_tdata,
    output int                              fail_count,
    output int                              outstanding,
    output int                              results_checked,
    output int                              events_recorded
);
    import mfewc_pkg::*;

    typedef struct {
        logic                     cmd;
        logic [TIME_W-1:0]        now;
        logic                     mgmt;
        logic [LEN_W-1:0]         len;
        logic [FC_W-1:0]          fc;
        logic signed [RSSI_W-1:0] rssi;
        logic [CHAN_W-1:0]        chan;
        logic [MAC_W-1:0]         dst;
        logic [MAC_W-1:0]         src;
    } frame_t;

    typedef struct {
        logic                recorded;
        logic [TIME_W-1:0]   total;
        logic [RECENT_W-1:0] recent;
        logic                last_valid;
        logic                last_deauth;
        logic [RSSI_W-1:0]   last_rssi;
        logic [CHAN_W-1:0]   last_chan;
        logic [MAC_W-1:0]    last_dst;
        logic [MAC_W-1:0]    last_src;
        logic [TIME_W-1:0]   last_time;
        logic [2:0]          pad;
    } window_stats_t;

    // Shadow copy of the event ring and the window register.
    logic [TIME_W-1:0] ring_time [RING_DEPTH];
    logic [MAC_W-1:0]  ring_dst  [RING_DEPTH];
    logic [MAC_W-1:0]  ring_src  [RING_DEPTH];
    event_meta_t       ring_meta [RING_DEPTH];
    int unsigned       slot_next = 0;
    int unsigned       slots_used = 0;
    logic [TIME_W-1:0] events_total = '0;
    logic [TIME_W-1:0] window_ms = 32'd10000;

    window_stats_t expected_stats [$];
    int errors = 0;
    int checked = 0;
    int recorded_n = 0;

    function automatic window_stats_t record_and_tally(input frame_t f);
        window_stats_t     r;
        logic [FC_W-1:0]   subtype;
        logic [TIME_W-1:0] age;
        int unsigned       hits;
        int unsigned       newest;
        event_meta_t       meta;
        r = '{default: '0};
        subtype = f.fc & SUBTYPE_MASK;
        hits = 0;
        if (f.cmd == CMD_FRAME && f.mgmt && f.len >= MIN_FRAME_LEN &&
            (subtype == KIND_DEAUTH || subtype == KIND_DISASSOC)) begin
            meta.is_deauth = (subtype == KIND_DEAUTH);
            meta.rssi      = f.rssi;
            meta.channel   = f.chan;
            ring_time[slot_next] = f.now;
            ring_dst[slot_next]  = f.dst;
            ring_src[slot_next]  = f.src;
            ring_meta[slot_next] = meta;
            slot_next = (slot_next + 1) % RING_DEPTH;
            if (slots_used < RING_DEPTH)
                slots_used++;
            events_total = events_total + 1'b1;
            r.recorded = 1'b1;
        end
        // The age wraps modulo 2^32, so an event stamped after now gets a very large age.
        for (int i = 0; i < slots_used; i++) begin
            age = f.now - ring_time[i];
            if (age <= window_ms)
                hits++;
        end
        r.total  = events_total;
        r.recent = (hits > RECENT_MAX) ? RECENT_MAX : RECENT_W'(hits);
        if (slots_used != 0) begin
            newest = (slot_next + RING_DEPTH - 1) % RING_DEPTH;
            meta = ring_meta[newest];
            r.last_valid  = 1'b1;
            r.last_deauth = meta.is_deauth;
            r.last_rssi   = meta.rssi;
            r.last_chan   = meta.channel;
            r.last_dst    = ring_dst[newest];
            r.last_src    = ring_src[newest];
            r.last_time   = ring_time[newest];
        end
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [MAC_W-1:0] want,
                                 input logic [MAC_W-1:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : watch
        frame_t        f;
        window_stats_t want;
        window_stats_t got;
        if (!aresetn) begin
            window_ms    = 32'd10000;
            slot_next    = 0;
            slots_used   = 0;
            events_total = '0;
            expected_stats.delete();
        end else begin
            if (cfg_wr_en)
                window_ms = cfg_wr_data;
            if (s_tvalid && s_tready) begin
                f.cmd  = s_tuser;
                f.now  = s_tdata[31:0];
                f.mgmt = s_tdata[32];
                f.len  = s_tdata[44:33];
                f.fc   = s_tdata[52:45];
                f.rssi = s_tdata[60:53];
                f.chan = s_tdata[64:61];
                f.dst  = s_tdata[112:65];
                f.src  = s_tdata[160:113];
                expected_stats.push_back(record_and_tally(f));
                if (expected_stats[$].recorded)
                    recorded_n++;
            end
            if (m_tvalid && m_tready) begin
                got.recorded    = m_tdata[0];
                got.total       = m_tdata[32:1];
                got.recent      = m_tdata[38:33];
                got.last_valid  = m_tdata[39];
                got.last_deauth = m_tdata[40];
                got.last_rssi   = m_tdata[48:41];
                got.last_chan   = m_tdata[52:49];
                got.last_dst    = m_tdata[100:53];
                got.last_src    = m_tdata[148:101];
                got.last_time   = m_tdata[180:149];
                got.pad         = m_tdata[183:181];
                if (expected_stats.size() == 0) begin
                    errors++;
                    $display("%0t ns: result item with none expected, got %h", $time, m_tdata);
                end else begin
                    want = expected_stats.pop_front();
                    compare_field("recorded", want.recorded, got.recorded);
                    compare_field("total_events", want.total, got.total);
                    compare_field("recent_events", want.recent, got.recent);
                    compare_field("last_valid", want.last_valid, got.last_valid);
                    compare_field("last_is_deauth", want.last_deauth, got.last_deauth);
                    compare_field("last_rssi", want.last_rssi, got.last_rssi);
                    compare_field("last_channel", want.last_chan, got.last_chan);
                    compare_field("last_dst", want.last_dst, got.last_dst);
                    compare_field("last_src", want.last_src, got.last_src);
                    compare_field("last_time", want.last_time, got.last_time);
                    compare_field("padding", want.pad, got.pad);
                    checked++;
                end
            end
        end
        fail_count      <= errors;
        outstanding     <= expected_stats.size();
        results_checked <= checked;
        events_recorded <= recorded_n;
    end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import mfewc_pkg::*;

    localparam int PHASES          = 5;
    localparam int ITEMS_PER_PHASE = 188;
    localparam int TIMEOUT_CYCLES  = 600000;

    typedef struct {
        logic                     cmd;
        logic [TIME_W-1:0]        now;
        logic                     mgmt;
        logic [LEN_W-1:0]         len;
        logic [FC_W-1:0]          fc;
        logic signed [RSSI_W-1:0] rssi;
        logic [CHAN_W-1:0]        chan;
        logic [MAC_W-1:0]         dst;
        logic [MAC_W-1:0]         src;
    } frame_t;

    typedef enum {NOISE_QUERY, NOISE_NOT_MGMT, NOISE_SHORT, NOISE_SUBTYPE, NOISE_ANY} noise_kind_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [TIME_W-1:0]    cfg_wr_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    int fail_count;
    int outstanding;
    int results_checked;
    int events_recorded;

    int unsigned       cycle_count = 0;
    int unsigned       stall_left = 0;
    int unsigned       stall_mode = 0;
    logic [TIME_W-1:0] clock_ms = '0;

    always #1 aclk = ~aclk;

    mgmt_frame_event_window_counter uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    event_window_checker u_stats_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .events_recorded (events_recorded)
    );

    // The receiver switches between always ready, coin-flip and long stalls.
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(20, 120);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == TIMEOUT_CYCLES) begin
            $display("Timed out after %0d cycles with %0d results pending.",
                     cycle_count, outstanding);
            $display("** mgmt_frame_event_window_counter: FAILED **");
            $finish;
        end
    end

    function automatic frame_t mk_frame(input logic cmd, input logic [TIME_W-1:0] now,
                                        input logic mgmt, input logic [LEN_W-1:0] len,
                                        input logic [FC_W-1:0] fc,
                                        input logic [RSSI_W-1:0] rssi,
                                        input logic [CHAN_W-1:0] chan,
                                        input logic [MAC_W-1:0] dst,
                                        input logic [MAC_W-1:0] src);
        frame_t f;
        f.cmd  = cmd;
        f.now  = now;
        f.mgmt = mgmt;
        f.len  = len;
        f.fc   = fc;
        f.rssi = rssi;
        f.chan = chan;
        f.dst  = dst;
        f.src  = src;
        return f;
    endfunction

    function automatic frame_t random_candidate();
        frame_t f;
        f.cmd  = CMD_FRAME;
        f.now  = '0;
        f.mgmt = 1'b1;
        f.len  = LEN_W'($urandom_range(MIN_FRAME_LEN, 4095));
        f.fc   = ($urandom_range(0, 1) ? KIND_DEAUTH : KIND_DISASSOC)
                 | FC_W'($urandom_range(0, 15));
        f.rssi = RSSI_W'($urandom);
        f.chan = CHAN_W'($urandom);
        f.dst  = MAC_W'({$urandom, $urandom});
        f.src  = MAC_W'({$urandom, $urandom});
        return f;
    endfunction

    function automatic frame_t random_noise();
        frame_t      f;
        noise_kind_t kind;
        f = random_candidate();
        kind = noise_kind_t'($urandom_range(0, 4));
        case (kind)
            NOISE_QUERY: f.cmd = CMD_QUERY;
            NOISE_NOT_MGMT: f.mgmt = 1'b0;
            NOISE_SHORT: f.len = LEN_W'($urandom_range(0, MIN_FRAME_LEN - 1));
            NOISE_SUBTYPE: begin
                do
                    f.fc = FC_W'($urandom);
                while ((f.fc & SUBTYPE_MASK) == KIND_DEAUTH ||
                       (f.fc & SUBTYPE_MASK) == KIND_DISASSOC);
            end
            default: begin
                f.cmd  = 1'($urandom);
                f.mgmt = 1'($urandom);
                f.len  = LEN_W'($urandom);
                f.fc   = FC_W'($urandom);
            end
        endcase
        return f;
    endfunction

    // Time mostly creeps forward, with an occasional jump anywhere in the 32-bit range.
    function automatic logic [TIME_W-1:0] next_now(input int unsigned step_hi);
        if ($urandom_range(0, 19) == 0)
            clock_ms = $urandom;
        else
            clock_ms = clock_ms + $urandom_range(0, step_hi);
        return clock_ms;
    endfunction

    // A zero gap keeps tvalid high straight into the next item.
    task automatic send_frame(input int unsigned gap, input frame_t f);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f.cmd;
        s_tdata  <= {7'd0, f.src, f.dst, f.chan, f.rssi, f.fc, f.len, f.mgmt, f.now};
        do
            @(posedge aclk);
        while (!s_tready);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge aclk);
        while (outstanding != 0);
    endtask

    task automatic write_window(input logic [TIME_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin : stimulus
        frame_t            f;
        frame_t            directed_q [$];
        logic [TIME_W-1:0] windows [PHASES];
        logic [TIME_W-1:0] start_ms [PHASES];
        int unsigned       step_hi [PHASES];
        int unsigned       burst_left;
        int unsigned       gap;
        int unsigned       items_sent;

        windows[0] = '0;
        windows[1] = '1;
        windows[2] = 32'd37;
        windows[3] = $urandom_range(100, 200000);
        windows[4] = 32'd10000;
        start_ms = '{32'd1000, 32'hFFFF_0000, 32'd500, $urandom, 32'hFFFF_F000};
        step_hi  = '{1, 60000, 2, windows[3] / 16 + 1, 600};
        burst_left = 0;
        items_sent = 0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed items under the reset window of 10000 ms.
        directed_q.push_back(mk_frame(CMD_QUERY, 32'd0, 1'b0, '0, '0, '0, '0, '0, '0));
        directed_q.push_back(mk_frame(CMD_FRAME, 32'd1, 1'b0, 12'd24, KIND_DEAUTH,
                                      8'd5, 4'd1, 48'h1, 48'h2));
        directed_q.push_back(mk_frame(CMD_FRAME, 32'd2, 1'b1, MIN_FRAME_LEN - 1, KIND_DEAUTH,
                                      8'd5, 4'd1, 48'h1, 48'h2));
        directed_q.push_back(mk_frame(CMD_FRAME, 32'd3, 1'b1, 12'd24, 8'hB0,
                                      8'd5, 4'd1, 48'h1, 48'h2));
        directed_q.push_back(mk_frame(CMD_QUERY, 32'd4, 1'b1, 12'd24, KIND_DEAUTH,
                                      8'd5, 4'd1, 48'h1, 48'h2));
        directed_q.push_back(mk_frame(CMD_FRAME, 32'hFFFF_FFFF, 1'b1, 12'd24, KIND_DEAUTH,
                                      8'h80, 4'hF, '1, '0));
        directed_q.push_back(mk_frame(CMD_FRAME, 32'd9999, 1'b1, 12'd4095, 8'hAF,
                                      8'h7F, 4'h0, '0, '1));
        directed_q.push_back(mk_frame(CMD_FRAME, 32'd10000, 1'b1, 12'd100, 8'hCF,
                                      8'hFF, 4'd6, 48'h0123_4567_89AB, 48'hBA98_7654_3210));
        // Ages exactly at the window edge, one past it, and stamps lying in the future.
        directed_q.push_back(mk_frame(CMD_QUERY, 32'd19999, '0, '0, '0, '0, '0, '0, '0));
        directed_q.push_back(mk_frame(CMD_QUERY, 32'd20000, '0, '0, '0, '0, '0, '0, '0));
        directed_q.push_back(mk_frame(CMD_QUERY, 32'd9998, '0, '0, '0, '0, '0, '0, '0));
        directed_q.push_back(mk_frame(CMD_FRAME, 32'd10001, 1'b1, 12'd64, 8'h0F,
                                      8'd20, 4'd3, '1, '1));
        directed_q.push_back(mk_frame(CMD_FRAME, 32'd10002, 1'b1, MIN_FRAME_LEN, KIND_DISASSOC,
                                      8'hC4, 4'd11, 48'hAAAA_5555_AAAA, 48'h5555_AAAA_5555));
        foreach (directed_q[i]) begin
            send_frame($urandom_range(0, 3), directed_q[i]);
            items_sent++;
        end

        for (int p = 0; p < PHASES; p++) begin
            // The block must be idle before the window changes.
            drain_results();
            write_window(windows[p]);
            clock_ms = start_ms[p];
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    if ($urandom_range(0, 15) == 0)
                        gap = $urandom_range(20, 60);
                end else begin
                    gap = 0;
                end
                burst_left--;
                f = ($urandom_range(0, 99) < 65) ? random_candidate() : random_noise();
                f.now = next_now(step_hi[p]);
                send_frame(gap, f);
                items_sent++;
            end
        end

        drain_results();
        repeat (RING_DEPTH + 8) @(posedge aclk);
        $display("Sent %0d items; %0d frames were recorded and %0d results were checked.",
                 items_sent, events_recorded, results_checked);
        $display("Windows covered: 10000 (reset), 0, 2^32-1, 37, %0d and 10000 again.",
                 windows[3]);
        if (fail_count == 0)
            $display("** mgmt_frame_event_window_counter: PASSED **");
        else
            $display("** mgmt_frame_event_window_counter: FAILED **");
        $finish;
    end

endmodule

// File: mgmt_frame_event_window_counter.f
design/mfewc_pkg.sv
design/mfewc_event_mem.sv
design/mfewc_window_scan.sv
design/mgmt_frame_event_window_counter.sv
sim/event_window_checker.sv
sim/tb.sv
